// ===== sv/kms_pkg.sv =====
package kms_pkg;

    // Window and result width: 31 bases, two bits each
    localparam int WIN_W  = 62;
    localparam int BASES  = 31;
    localparam int KLEN_W = 6;
    localparam int PLEN_W = 5;
    localparam int POS_W  = 5;

    localparam int DEF_MAX_K = 32;

    localparam logic [KLEN_W-1:0] KLEN_RST = 6'd32;
    localparam logic [PLEN_W-1:0] PLEN_RST = 5'd10;

    // Register indexes on the APB port (word address bit 2)
    localparam logic REG_KLEN = 1'b0;
    localparam logic REG_PLEN = 1'b1;

    // Control travelling alongside a request through the pipeline
    typedef struct packed {
        logic              vld;
        logic [PLEN_W-1:0] plen;
    } t_ctl;

    // Reverse complement of the whole 31-base word; the first len bases of the
    // result are the reverse complement of the low len bases of the input
    function automatic logic [WIN_W-1:0] revcomp_all(input logic [WIN_W-1:0] w);
        logic [WIN_W-1:0] r;
        r = '0;
        for (int i = 0; i < BASES; i++) begin
            r[2*(BASES-1-i) +: 2] = ~w[2*i +: 2];
        end
        return r;
    endfunction

endpackage

// ===== sv/kms_lane.sv =====
module kms_lane #(
    parameter int LANE = 0
) (
    input  logic                       i_clk,
    input  logic [kms_pkg::WIN_W-1:0]  i_win,
    input  logic [kms_pkg::WIN_W-1:0]  i_pmask,
    input  logic [kms_pkg::POS_W-1:0]  i_npos,
    output logic [kms_pkg::WIN_W-1:0]  o_cand,
    output logic                       o_ok
);

    logic [kms_pkg::WIN_W-1:0] r_cand;
    logic                      r_ok;

    // Candidate starting LANE bases from the top, kept left-aligned and masked
    // to p bases so that numeric order is lexicographic order
    always_ff @(posedge i_clk) begin
        r_cand <= (i_win << (2 * LANE)) & i_pmask;
        r_ok   <= (kms_pkg::POS_W'(LANE) < i_npos);
    end

    assign o_cand = r_cand;
    assign o_ok   = r_ok;

endmodule

// ===== sv/kms_merge.sv =====
module kms_merge #(
    parameter int NLANE = kms_pkg::DEF_MAX_K - 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [kms_pkg::WIN_W-1:0]  i_cand [0:NLANE-1],
    input  logic                       i_ok   [0:NLANE-1],
    input  kms_pkg::t_ctl              i_ctl,
    output logic [kms_pkg::WIN_W-1:0]  o_best,
    output kms_pkg::t_ctl              o_ctl
);

    localparam int LEVELS = $clog2(NLANE);
    localparam int NPAD   = 1 << LEVELS;

    logic [kms_pkg::WIN_W-1:0] r_val [1:LEVELS][0:NPAD/2-1];
    logic                      r_ok  [1:LEVELS][0:NPAD/2-1];
    kms_pkg::t_ctl             r_ctl [1:LEVELS];

    // Registered minimum tree, one level per stage; earlier lane wins a tie
    for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
        for (genvar j = 0; j < (NPAD >> l); j++) begin : g_node
            logic [kms_pkg::WIN_W-1:0] a_v;
            logic [kms_pkg::WIN_W-1:0] b_v;
            logic                      a_ok;
            logic                      b_ok;
            logic                      take_b;

            if (l == 1) begin : g_leaf
                if (2*j < NLANE) begin : g_a
                    assign a_v  = i_cand[2*j];
                    assign a_ok = i_ok[2*j];
                end else begin : g_a_pad
                    assign a_v  = '0;
                    assign a_ok = 1'b0;
                end
                if (2*j+1 < NLANE) begin : g_b
                    assign b_v  = i_cand[2*j+1];
                    assign b_ok = i_ok[2*j+1];
                end else begin : g_b_pad
                    assign b_v  = '0;
                    assign b_ok = 1'b0;
                end
            end else begin : g_inner
                assign a_v  = r_val[l-1][2*j];
                assign a_ok = r_ok[l-1][2*j];
                assign b_v  = r_val[l-1][2*j+1];
                assign b_ok = r_ok[l-1][2*j+1];
            end

            assign take_b = b_ok && (!a_ok || (b_v < a_v));

            always_ff @(posedge i_clk) begin
                r_val[l][j] <= take_b ? b_v : a_v;
                r_ok[l][j]  <= a_ok || b_ok;
            end
        end

        // Request control follows the tree levels
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[l] <= '0;
            end else if (l == 1) begin
                r_ctl[l] <= i_ctl;
            end else begin
                r_ctl[l] <= r_ctl[(l > 1) ? l-1 : 1];
            end
        end
    end

    assign o_best = r_val[LEVELS][0];
    assign o_ctl  = r_ctl[LEVELS];

endmodule

// ===== sv/kmer_minimizer_select.sv =====
// Minimizer selection for one DNA window per request.
// A request passes the input stage, lane registers, minimum tree and output stage to o_done.
// Throughput: one request per cycle; busy is always low, results come out in order.
// The MAX_K-1 candidate lanes and the registered minimum tree are fully pipelined.
// Reset (synchronous, active low) clears the pipeline control and sets k = 32, p = 10.
module kmer_minimizer_select #(
    parameter int MAX_K = kms_pkg::DEF_MAX_K
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       start,
    output logic                       busy,
    input  logic [kms_pkg::WIN_W-1:0]  i_window_bases,
    input  logic                       i_use_revcomp,
    output logic                       o_done,
    output logic [kms_pkg::WIN_W-1:0]  o_minimizer_bases
);

    localparam int NLANE = MAX_K - 1;
    localparam logic [kms_pkg::KLEN_W-1:0] KMAX = kms_pkg::KLEN_W'(MAX_K);

    logic [kms_pkg::KLEN_W-1:0] r_kmer_len;
    logic [kms_pkg::PLEN_W-1:0] r_minimizer_len;

    logic [kms_pkg::KLEN_W-1:0] k_use;
    logic [kms_pkg::POS_W-1:0]  len;
    logic [kms_pkg::PLEN_W-1:0] p_nz;
    logic [kms_pkg::PLEN_W-1:0] p_use;
    logic [kms_pkg::POS_W-1:0]  npos;
    logic [5:0]                 al_sh;
    logic [kms_pkg::WIN_W-1:0]  win_al;
    logic [kms_pkg::WIN_W-1:0]  pmask;

    logic [kms_pkg::WIN_W-1:0]  r_a_win;
    logic [kms_pkg::WIN_W-1:0]  r_a_pmask;
    logic [kms_pkg::POS_W-1:0]  r_a_npos;
    kms_pkg::t_ctl              r_a_ctl;
    kms_pkg::t_ctl              r_b_ctl;

    logic [kms_pkg::WIN_W-1:0]  lane_cand [0:NLANE-1];
    logic                       lane_ok   [0:NLANE-1];

    logic [kms_pkg::WIN_W-1:0]  best;
    kms_pkg::t_ctl              best_ctl;

    logic                       r_done;
    logic [kms_pkg::WIN_W-1:0]  r_result;

    // APB register file, always ready, word decode on paddr[2]
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len      <= kms_pkg::KLEN_RST;
            r_minimizer_len <= kms_pkg::PLEN_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                kms_pkg::REG_KLEN: r_kmer_len      <= pwdata[kms_pkg::KLEN_W-1:0];
                kms_pkg::REG_PLEN: r_minimizer_len <= pwdata[kms_pkg::PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            kms_pkg::REG_KLEN: prdata = {{(32-kms_pkg::KLEN_W){1'b0}}, r_kmer_len};
            kms_pkg::REG_PLEN: prdata = {{(32-kms_pkg::PLEN_W){1'b0}}, r_minimizer_len};
            default:           prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign busy   = 1'b0;

    // Clamp k and p, work out candidate count
    always_comb begin
        if (r_kmer_len < 6'd2) begin
            k_use = 6'd2;
        end else if (r_kmer_len > KMAX) begin
            k_use = KMAX;
        end else begin
            k_use = r_kmer_len;
        end
        len   = kms_pkg::POS_W'(k_use - 6'd1);
        p_nz  = (r_minimizer_len == '0) ? 5'd1 : r_minimizer_len;
        p_use = (p_nz > len) ? len : p_nz;
        npos  = kms_pkg::POS_W'(len - p_use + 5'd1);
    end

    // Left-align the window: first base at the top; revcomp already lands there
    assign al_sh  = {kms_pkg::POS_W'(kms_pkg::BASES) - len, 1'b0};
    assign win_al = i_use_revcomp ? kms_pkg::revcomp_all(i_window_bases)
                                  : (i_window_bases << al_sh);
    assign pmask  = ~({kms_pkg::WIN_W{1'b1}} >> {p_use, 1'b0});

    // Input stage
    always_ff @(posedge i_clk) begin
        r_a_win   <= win_al;
        r_a_pmask <= pmask;
        r_a_npos  <= npos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
        end else begin
            r_a_ctl <= '{vld: start, plen: p_use};
            r_b_ctl <= r_a_ctl;
        end
    end

    // One lane per window position
    for (genvar i = 0; i < NLANE; i++) begin : g_lane
        kms_lane #(
            .LANE (i)
        ) u_lane (
            .i_clk   (i_clk),
            .i_win   (r_a_win),
            .i_pmask (r_a_pmask),
            .i_npos  (r_a_npos),
            .o_cand  (lane_cand[i]),
            .o_ok    (lane_ok[i])
        );
    end

    kms_merge #(
        .NLANE (NLANE)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cand  (lane_cand),
        .i_ok    (lane_ok),
        .i_ctl   (r_b_ctl),
        .o_best  (best),
        .o_ctl   (best_ctl)
    );

    // Output stage: move the winner down to the low 2p bits
    always_ff @(posedge i_clk) begin
        r_result <= best >> (6'(kms_pkg::WIN_W) - {best_ctl.plen, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= best_ctl.vld;
        end
    end

    assign o_done            = r_done;
    assign o_minimizer_bases = r_result;

endmodule
